@@ hw/rtl/unsigned_to_radix_text_top_assert.svh @@
// Assertion macros for the radix text converter.
// Included by the top level; the macros name its clk and rst_n signals.
`ifndef UNSIGNED_TO_RADIX_TEXT_TOP_ASSERT_SVH
`define UNSIGNED_TO_RADIX_TEXT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define UTRT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define UTRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define UTRT_ASSERT_SAME(lbl, ante, cons)
`define UTRT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/utrt_pkg.sv @@
// Shared constants and helper functions for the radix text converter.
// No dependencies.
package utrt_pkg;

    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 6;
    localparam int DIGIT_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int LEN_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int OUT_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_CASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_PREFIX = 2'd3;

    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] RADIX_HEX   = 6'd16;
    localparam logic [DIGIT_W-1:0] RADIX_OCT   = 6'd8;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [DIGIT_W-1:0] LETTER_X_DIGIT = 6'd33;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic up);
        logic [CHAR_W-1:0] base;
        base = up ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (d < 6'd10)
        begin
            digit_char = CHAR_ZERO + {1'b0, d};
        end
        else
        begin
            digit_char = base + {1'b0, d} - 7'd10;
        end
    endfunction

    // Floor of log2 of the radix; each division shrinks the value by this many bits.
    function automatic logic [2:0] radix_log2(input logic [DIGIT_W-1:0] r);
        if (r[5])
        begin
            radix_log2 = 3'd5;
        end
        else if (r[4])
        begin
            radix_log2 = 3'd4;
        end
        else if (r[3])
        begin
            radix_log2 = 3'd3;
        end
        else if (r[2])
        begin
            radix_log2 = 3'd2;
        end
        else
        begin
            radix_log2 = 3'd1;
        end
    endfunction

endpackage

@@ hw/rtl/unsigned_to_radix_text_top.sv @@
// Radix text converter: one unsigned value in, its ASCII text out, one character per item.
// Depends on utrt_pkg and unsigned_to_radix_text_top_assert.svh.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       number
//   m_axis    out        m_axis_tvalid/tready       char_code, text_length, is_last on tlast
//   cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// Digits come from one shared restoring divider that retires one quotient bit per cycle.
// Each digit divides the low w bits of the value, where w starts at VALUE_BITS and drops
// by floor(log2(radix)) after every digit; a closing check and planning follow the last
// digit, and each character is read from the digit memory before it is sent.
// Reset clears the sequencer, counters and registers except out_char_reg, rd_reg and memory.
// The input is not ready until the last character has been loaded into the output register.
// A stalled output holds its item; the sequencer waits in ST_SEND until it is taken.
`include "unsigned_to_radix_text_top_assert.svh"

module unsigned_to_radix_text_top #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Bits from the lowest up: number.
    input  logic [((VALUE_BITS+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // Bits from the lowest up: char_code, text_length, zero fill.
    output logic [utrt_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    output logic                                    m_axis_tlast,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [utrt_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [utrt_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import utrt_pkg::*;

    localparam int BIDX_W = $clog2(VALUE_BITS);
    localparam int WID_W  = $clog2(VALUE_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_PLAN,
        ST_START,
        ST_FETCH,
        ST_SEND
    } state_t;

    state_t                 state_reg, state_next;
    logic [DIGIT_W-1:0]     radix_reg, radix_next;
    logic [DIGIT_W-1:0]     min_reg, min_next;
    logic                   upper_reg, upper_next;
    logic                   alt_reg, alt_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic                   nonzero_reg, nonzero_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [BIDX_W-1:0]      bidx_reg, bidx_next;
    logic [WID_W-1:0]       wid_reg, wid_next;
    logic [COUNT_W-1:0]     ndig_reg, ndig_next;
    logic [1:0]             plen_reg, plen_next;
    logic [LEN_W-1:0]       pad_reg, pad_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LEN_W-1:0]       pos_reg, pos_next;
    logic [COUNT_W-1:0]     total_reg, total_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;
    logic [COUNT_W-1:0]     out_len_reg, out_len_next;

    logic [DIGIT_W-1:0]     digit_mem [DIGIT_DEPTH];
    logic [DIGIT_W-1:0]     rd_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [DIGIT_W-1:0]     mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;

    logic                   in_fire;
    logic [CHAR_W-1:0]      trial;
    logic                   ge;
    logic [CHAR_W-1:0]      diff;
    logic [2:0]             lg;
    logic [LEN_W-1:0]       pad0;
    logic [LEN_W-1:0]       raw_len;
    logic [LEN_W-1:0]       excess;
    logic [LEN_W-1:0]       len_m1;
    logic [LEN_W-1:0]       max_len;
    logic                   send_ok;
    logic                   is_last;
    logic [CHAR_W-1:0]      ch;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - CHAR_W - COUNT_W){1'b0}}, out_len_reg, out_char_reg};

    assign max_len = LEN_W'(MAX_DIGITS);
    assign len_m1  = len_reg - 8'd1;

    always_comb
    begin
        state_next     = state_reg;
        radix_next     = radix_reg;
        min_next       = min_reg;
        upper_next     = upper_reg;
        alt_next       = alt_reg;
        val_next       = val_reg;
        nonzero_next   = nonzero_reg;
        rem_next       = rem_reg;
        bidx_next      = bidx_reg;
        wid_next       = wid_reg;
        ndig_next      = ndig_reg;
        plen_next      = plen_reg;
        pad_next       = pad_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_len_next   = out_len_reg;
        mem_we         = 1'b0;
        mem_waddr      = ndig_reg[ADDR_W-1:0];
        mem_re         = 1'b0;
        mem_raddr      = len_m1[ADDR_W-1:0] - pos_reg[ADDR_W-1:0];

        trial  = {rem_reg, val_reg[bidx_reg]};
        ge     = trial >= {1'b0, radix_reg};
        diff   = trial - {1'b0, radix_reg};
        mem_wdata = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        lg     = radix_log2(radix_reg);

        pad0    = ({2'b00, min_reg} > {1'b0, ndig_reg})
                  ? ({2'b00, min_reg} - {1'b0, ndig_reg}) : '0;
        raw_len = {6'd0, plen_reg} + pad0 + {1'b0, ndig_reg};
        excess  = raw_len - max_len;

        send_ok = !out_valid_reg || m_axis_tready;
        is_last = (pos_reg == len_m1);
        if (pos_reg < {6'd0, plen_reg})
        begin
            ch = (pos_reg == 8'd1) ? digit_char(LETTER_X_DIGIT, upper_reg) : CHAR_ZERO;
        end
        else if (pos_reg < ({6'd0, plen_reg} + pad_reg))
        begin
            ch = CHAR_ZERO;
        end
        else
        begin
            ch = digit_char(rd_reg, upper_reg);
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RADIX:      radix_next = cfg_data;
                CFG_MIN_DIGITS: min_next   = cfg_data;
                CFG_UPPER_CASE: upper_next = cfg_data[0];
                CFG_ALT_PREFIX: alt_next   = cfg_data[0];
                default:        radix_next = radix_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && radix_reg >= RADIX_MIN && radix_reg <= RADIX_MAX)
                begin
                    val_next     = s_axis_tdata[VALUE_BITS-1:0];
                    nonzero_next = (s_axis_tdata[VALUE_BITS-1:0] != '0);
                    ndig_next    = '0;
                    wid_next     = WID_W'(VALUE_BITS);
                    rem_next     = '0;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (val_reg == '0 && ndig_reg != '0)
                begin
                    state_next = ST_PLAN;
                end
                else
                begin
                    bidx_next  = BIDX_W'(wid_reg - 1'b1);
                    rem_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                val_next[bidx_reg] = ge;
                rem_next           = mem_wdata;
                if (bidx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    ndig_next  = ndig_reg + 1'b1;
                    wid_next   = (wid_reg > WID_W'(lg)) ? (wid_reg - WID_W'(lg)) : WID_W'(1);
                    state_next = ST_CHECK;
                end
                else
                begin
                    bidx_next = bidx_reg - 1'b1;
                end
            end
            ST_PLAN:
            begin
                if (alt_reg && radix_reg == RADIX_HEX)
                begin
                    plen_next = 2'd2;
                end
                else if (alt_reg && radix_reg == RADIX_OCT && nonzero_reg)
                begin
                    plen_next = 2'd1;
                end
                else
                begin
                    plen_next = 2'd0;
                end
                pad_next   = pad0;
                state_next = ST_START;
            end
            ST_START:
            begin
                // Padding is trimmed first when the text would overflow.
                if (raw_len > max_len)
                begin
                    pad_next = (excess >= pad0) ? '0 : (pad0 - excess);
                end
                state_next = ST_FETCH;
                len_next   = {6'd0, plen_reg} + pad_next + {1'b0, ndig_reg};
                pos_next   = (len_next > max_len) ? (len_next - max_len) : '0;
                total_next = COUNT_W'(len_next - pos_next);
            end
            ST_FETCH:
            begin
                mem_re     = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (send_ok)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ch;
                    out_last_next  = is_last;
                    out_len_next   = is_last ? total_reg : '0;
                    pos_next       = pos_reg + 1'b1;
                    state_next     = is_last ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            min_reg       <= '0;
            upper_reg     <= 1'b0;
            alt_reg       <= 1'b0;
            val_reg       <= '0;
            nonzero_reg   <= 1'b0;
            rem_reg       <= '0;
            bidx_reg      <= '0;
            wid_reg       <= '0;
            ndig_reg      <= '0;
            plen_reg      <= '0;
            pad_reg       <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_len_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            radix_reg     <= radix_next;
            min_reg       <= min_next;
            upper_reg     <= upper_next;
            alt_reg       <= alt_next;
            val_reg       <= val_next;
            nonzero_reg   <= nonzero_next;
            rem_reg       <= rem_next;
            bidx_reg      <= bidx_next;
            wid_reg       <= wid_next;
            ndig_reg      <= ndig_next;
            plen_reg      <= plen_next;
            pad_reg       <= pad_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            out_len_reg   <= out_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= digit_mem[mem_raddr];
        end
    end

    `UTRT_ASSERT_SAME(a_rem_below_radix, state_reg == ST_DIV, rem_reg < radix_reg)
    `UTRT_ASSERT_SAME(a_digit_count_bound, 1'b1, ndig_reg <= COUNT_W'(DIGIT_DEPTH))
    `UTRT_ASSERT_SAME(a_last_has_length, m_axis_tvalid,
                      m_axis_tlast == (m_axis_tdata[CHAR_W+COUNT_W-1:CHAR_W] != '0))
    `UTRT_ASSERT_NEXT(a_send_fills_output, state_reg == ST_SEND && send_ok, m_axis_tvalid)

endmodule
